>>> rtl/rcfd_pkg.sv
// Shared types and constants of the receiver frame decoder.
package rcfd_pkg;

    localparam int FRAME_BYTES  = 32;
    localparam int NUM_CHANNELS = 14;
    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int CH_W         = $clog2(NUM_CHANNELS);

    localparam logic [7:0]       HDR_FIRST   = 8'h20;
    localparam logic [7:0]       HDR_SECOND  = 8'h40;
    localparam logic [15:0]      SUM_START   = 16'hFFFF;
    localparam logic [15:0]      SUM_LOCKED  = SUM_START - 16'(HDR_FIRST) - 16'(HDR_SECOND);
    localparam logic [POS_W-1:0] POS_FIRST   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CHK_LO  = POS_W'(30);
    localparam logic [POS_W-1:0] POS_CHK_HI  = POS_W'(31);
    localparam logic [CH_W-1:0]  CH_COUNT    = CH_W'(NUM_CHANNELS);
    localparam logic [CH_W-1:0]  CH_LAST     = CH_W'(NUM_CHANNELS - 1);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_HDR   = 2'd1,
        PH_FRAME = 2'd2
    } phase_t;

    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] addr;
        logic [15:0]     data;
    } wr_req_t;

    typedef struct packed {
        logic            active;
        logic [CH_W-1:0] idx;
    } drain_stat_t;

endpackage

>>> rtl/rcfd_chan_store.sv
// Channel memory with the drain sequencer and the registered result output.
module rcfd_chan_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rcfd_pkg::wr_req_t      wr,
    input  logic                   start,
    output rcfd_pkg::drain_stat_t  drain,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [3:0]             chan_index,
    output logic [15:0]            chan_value,
    output logic                   last_chan
);
    import rcfd_pkg::*;

    logic [15:0]     mem [NUM_CHANNELS];
    logic [15:0]     data_reg;
    logic [CH_W-1:0] idx_reg;
    logic            last_reg;
    logic            out_valid_reg;
    logic            active_reg;
    logic [CH_W-1:0] drain_idx_reg;
    logic            rd_en;

    assign rd_en = active_reg && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            data_reg <= mem[drain_idx_reg];
            idx_reg  <= drain_idx_reg;
            last_reg <= (drain_idx_reg == CH_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            drain_idx_reg <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (start)
            begin
                active_reg    <= 1'b1;
                drain_idx_reg <= '0;
            end
            else if (rd_en)
            begin
                if (drain_idx_reg == CH_LAST)
                begin
                    active_reg <= 1'b0;
                end
                drain_idx_reg <= drain_idx_reg + CH_W'(1);
            end
        end
    end

    assign drain.active = active_reg;
    assign drain.idx    = drain_idx_reg;
    assign out_valid    = out_valid_reg;
    assign chan_index   = 4'(idx_reg);
    assign chan_value   = data_reg;
    assign last_chan    = last_reg;

endmodule

>>> rtl/rc_receiver_frame_decoder.sv
// Top level of the receiver frame decoder: header hunt, checksum and channel drain.
//
//  Channel | Handshake            | Payload
//  input   | in_valid / in_stall  | rx_byte[7:0]
//  output  | out_valid / out_stall| chan_index[3:0], chan_value[15:0], last_chan
//
// One request is taken per cycle unless in_stall is high; a verified frame yields 14 results,
// one per cycle unless out_stall holds them, each registered from the channel memory.
// Reset returns the parser to header hunt and empties the output register.
// While results drain, input stalls only on a byte that would overwrite a channel
// not yet read, or on the final byte of the next frame.
// A stall on the output while a result is valid holds it and pauses the memory reads.
module rc_receiver_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  chan_index,
    output logic [15:0] chan_value,
    output logic        last_chan
);
    import rcfd_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] count_reg, count_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       pend_reg, pend_next;
    logic [7:0]       chk_reg, chk_next;
    logic             accept;
    logic [CH_W-1:0]  ch;
    wr_req_t          wr;
    logic             start;
    drain_stat_t      drain;

    assign ch     = CH_W'(count_reg[POS_W-1:1] - 4'd1);
    assign accept = in_valid && !in_stall;

    assign in_stall = drain.active && (phase_reg == PH_FRAME) &&
                      ((count_reg == POS_CHK_HI) ||
                       ((count_reg < POS_CHK_LO) && count_reg[0] && (ch >= drain.idx)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            sum_reg   <= SUM_START;
            pend_reg  <= '0;
            chk_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            pend_reg  <= pend_next;
            chk_reg   <= chk_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        pend_next  = pend_reg;
        chk_next   = chk_reg;
        wr.en      = 1'b0;
        wr.addr    = ch;
        wr.data    = {rx_byte, pend_reg};
        start      = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_FRAME:
                begin
                    if (count_reg < POS_CHK_LO)
                    begin
                        sum_next = sum_reg - 16'(rx_byte);
                        if (!count_reg[0])
                        begin
                            pend_next = rx_byte;
                        end
                        else if (ch < CH_COUNT)
                        begin
                            wr.en = 1'b1;
                        end
                        count_next = count_reg + POS_W'(1);
                    end
                    else if (count_reg == POS_CHK_LO)
                    begin
                        chk_next   = rx_byte;
                        count_next = count_reg + POS_W'(1);
                    end
                    else
                    begin
                        start      = ({rx_byte, chk_reg} == sum_reg);
                        phase_next = PH_HUNT;
                        count_next = '0;
                        sum_next   = SUM_START;
                    end
                end
                PH_HDR:
                begin
                    if (rx_byte == HDR_SECOND)
                    begin
                        phase_next = PH_FRAME;
                        count_next = POS_FIRST;
                        sum_next   = SUM_LOCKED;
                    end
                    else if (rx_byte != HDR_FIRST)
                    begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        sum_next   = SUM_START;
                    end
                end
                default:
                begin
                    if (rx_byte == HDR_FIRST)
                    begin
                        phase_next = PH_HDR;
                        count_next = POS_W'(1);
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        sum_next   = SUM_START;
                    end
                end
            endcase
        end
    end

    rcfd_chan_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .start      (start),
        .drain      (drain),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .chan_index (chan_index),
        .chan_value (chan_value),
        .last_chan  (last_chan)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_chan |-> chan_index == 4'(CH_LAST))
        else $error("last channel flag on wrong index");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_chan |=>
            out_valid && chan_index == $past(chan_index) + 4'd1)
        else $error("channel results not in order");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr.en && drain.active |-> wr.addr < drain.idx)
        else $error("channel overwritten before it was read");

    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !drain.active)
        else $error("new frame verified while previous frame drains");

endmodule
